FILE: hdl/qnl_pkg.sv
// shared constants for the quaternion normalized lerp core
`default_nettype none
package qnl_pkg;
   localparam int COMPONENT_BITS      = 16;
   localparam int BLEND_FRACTION_BITS = 16;
   localparam int LANES               = 4;
   localparam int NORM_TOP            = 30;
   localparam int ROOT_BITS           = NORM_TOP + 1;
   localparam int RAD_BITS            = 2 * ROOT_BITS;
endpackage
`default_nettype wire

FILE: hdl/qnl_lane.sv
// one component lane: dot product term, blend, magnitude, normalize shift and square
`default_nettype none
module qnl_lane #(
   parameter int CW = qnl_pkg::COMPONENT_BITS,
   parameter int BW = qnl_pkg::BLEND_FRACTION_BITS,
   localparam int PW = CW + BW + 3,
   localparam int MW = CW + BW + 1,
   localparam int LENW = $clog2(MW + 1),
   localparam int SHW = qnl_pkg::NORM_TOP
) (
   input  wire                     clock,
   input  wire                     en,
   input  wire  signed [CW-1:0]    a,
   input  wire  signed [CW-1:0]    b,
   input  wire         [BW:0]      f,
   input  wire                     neg,
   input  wire         [LENW-1:0]  len,
   output logic signed [2*CW-1:0]  prod,
   output logic        [MW-1:0]    mag,
   output logic                    sign_out,
   output logic        [SHW-1:0]   sh_out,
   output logic        [2*SHW-1:0] sq
);
   localparam int WW = MW + SHW;

   logic signed [2*CW-1:0] prod_ff;
   logic signed [CW-1:0]   a1_ff, b1_ff, a2_ff, b2_ff, a3_ff;
   logic        [BW:0]     f1_ff, f2_ff;
   logic signed [PW-1:0]   dprod_ff, l_ff;
   logic        [MW-1:0]   mag5_ff;
   logic                   sg5_ff, sg6_ff, sg7_ff, sg8_ff;
   logic        [SHW-1:0]  sh6_ff, sh7_ff, sh8_ff;
   logic        [2*SHW-1:0] sq7_ff;

   logic signed [CW:0]     d_in;
   logic signed [BW+1:0]   fs;
   logic signed [PW-1:0]   ash, l_in, lneg;
   logic        [WW-1:0]   wide;

   always_comb begin
      d_in = neg ? ({a2_ff[CW-1], a2_ff} + {b2_ff[CW-1], b2_ff})
                 : ({a2_ff[CW-1], a2_ff} - {b2_ff[CW-1], b2_ff});
      fs   = {1'b0, f2_ff};
      ash  = {{(PW-CW-BW){a3_ff[CW-1]}}, a3_ff, {BW{1'b0}}};
      l_in = ash - dprod_ff;
      lneg = -l_ff;
      mag  = l_ff[PW-1] ? lneg[MW-1:0] : l_ff[MW-1:0];
      wide = {mag5_ff, {SHW{1'b0}}} >> len;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= a * b;
         a1_ff    <= a;
         b1_ff    <= b;
         f1_ff    <= f;
         a2_ff    <= a1_ff;
         b2_ff    <= b1_ff;
         f2_ff    <= f1_ff;
         dprod_ff <= d_in * fs;
         a3_ff    <= a2_ff;
         l_ff     <= l_in;
         mag5_ff  <= mag;
         sg5_ff   <= l_ff[PW-1];
         sh6_ff   <= wide[SHW-1:0];
         sg6_ff   <= sg5_ff;
         sq7_ff   <= sh6_ff * sh6_ff;
         sh7_ff   <= sh6_ff;
         sg7_ff   <= sg6_ff;
         sh8_ff   <= sh7_ff;
         sg8_ff   <= sg7_ff;
      end
   end

   assign prod     = prod_ff;
   assign sq       = sq7_ff;
   assign sh_out   = sh8_ff;
   assign sign_out = sg8_ff;
endmodule
`default_nettype wire

FILE: hdl/qnl_sqrt.sv
// pipelined integer square root, one root bit per stage
`default_nettype none
module qnl_sqrt #(
   parameter int SIDE_W = 1,
   localparam int RW = qnl_pkg::ROOT_BITS,
   localparam int SW = qnl_pkg::RAD_BITS
) (
   input  wire               clock,
   input  wire               en,
   input  wire  [SW-1:0]     rad,
   input  wire  [SIDE_W-1:0] side_in,
   output logic [RW-1:0]     root,
   output logic [SIDE_W-1:0] side_out
);
   logic [SW-1:0]     rem_ff  [1:RW];
   logic [RW-1:0]     root_ff [1:RW];
   logic [SIDE_W-1:0] side_ff [1:RW];

   for (genvar i = 0; i < RW; i++) begin : g_stage
      localparam int BP = RW - 1 - i;
      logic [SW-1:0]     cur_rem, trial;
      logic [RW-1:0]     cur_root;
      logic [SIDE_W-1:0] cur_side;
      if (i == 0) begin : g_first
         assign cur_rem  = rad;
         assign cur_root = '0;
         assign cur_side = side_in;
      end else begin : g_next
         assign cur_rem  = rem_ff[i];
         assign cur_root = root_ff[i];
         assign cur_side = side_ff[i];
      end
      assign trial = (SW'(cur_root) << (BP + 1)) | (SW'(1) << (2 * BP));
      always_ff @(posedge clock) begin
         if (en) begin
            if (cur_rem >= trial) begin
               rem_ff[i+1]  <= cur_rem - trial;
               root_ff[i+1] <= cur_root | (RW'(1) << BP);
            end else begin
               rem_ff[i+1]  <= cur_rem;
               root_ff[i+1] <= cur_root;
            end
            side_ff[i+1] <= cur_side;
         end
      end
   end

   assign root     = root_ff[RW];
   assign side_out = side_ff[RW];
endmodule
`default_nettype wire

FILE: hdl/qnl_div.sv
// pipelined rounded division of a normalized magnitude by the root
`default_nettype none
module qnl_div #(
   parameter int CW = qnl_pkg::COMPONENT_BITS,
   parameter int SIDE_W = 1,
   localparam int RW = qnl_pkg::ROOT_BITS,
   localparam int SHW = qnl_pkg::NORM_TOP
) (
   input  wire               clock,
   input  wire               en,
   input  wire  [SHW-1:0]    m,
   input  wire  [RW-1:0]     root,
   input  wire  [SIDE_W-1:0] side_in,
   output logic [CW-1:0]     q,
   output logic [SIDE_W-1:0] side_out
);
   localparam int QW = CW;
   localparam int NW = RW + QW;

   logic [NW-1:0]     rem_ff  [0:QW];
   logic [RW-1:0]     den_ff  [0:QW];
   logic [QW-1:0]     q_ff    [0:QW];
   logic [SIDE_W-1:0] side_ff [0:QW];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= (NW'(m) << (CW - 2)) + NW'(root >> 1);
         den_ff[0]  <= root;
         q_ff[0]    <= '0;
         side_ff[0] <= side_in;
      end
   end

   for (genvar i = 0; i < QW; i++) begin : g_stage
      localparam int BP = QW - 1 - i;
      logic [NW-1:0] trial;
      assign trial = NW'(den_ff[i]) << BP;
      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_ff[i] >= trial) begin
               rem_ff[i+1] <= rem_ff[i] - trial;
               q_ff[i+1]   <= q_ff[i] | (QW'(1) << BP);
            end else begin
               rem_ff[i+1] <= rem_ff[i];
               q_ff[i+1]   <= q_ff[i];
            end
            den_ff[i+1]  <= den_ff[i];
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign q        = q_ff[QW];
   assign side_out = side_ff[QW];
endmodule
`default_nettype wire

FILE: hdl/quaternion_nlerp_core.sv
// top level of the quaternion normalized lerp core
// throughput: one transaction per cycle while results are taken; the root stage (one bit
//   per stage) and the per-lane division pipelines (one quotient bit per stage) set the depth
// a result not taken stalls the whole pipeline in place
// reset clears the valid bits only; data registers are not reset
`default_nettype none
module quaternion_nlerp_core #(
   parameter int COMPONENT_BITS      = qnl_pkg::COMPONENT_BITS,
   parameter int BLEND_FRACTION_BITS = qnl_pkg::BLEND_FRACTION_BITS,
   localparam int CW   = COMPONENT_BITS,
   localparam int BW   = BLEND_FRACTION_BITS,
   localparam int INW  = ((8 * CW + BW + 1 + 7) / 8) * 8,
   localparam int OUTW = ((4 * CW + 7) / 8) * 8
) (
   input  wire             clock,
   input  wire             reset,
   input  wire             req_tvalid,
   output logic            req_tready,
   // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend
   input  wire  [INW-1:0]  req_tdata,
   output logic            rsp_tvalid,
   input  wire             rsp_tready,
   // out_x, out_y, out_z, out_w
   output logic [OUTW-1:0] rsp_tdata,
   // zero_length
   output logic [0:0]      rsp_tuser
);
   localparam int L    = qnl_pkg::LANES;
   localparam int MW   = CW + BW + 1;
   localparam int LENW = $clog2(MW + 1);
   localparam int SHW  = qnl_pkg::NORM_TOP;
   localparam int RW   = qnl_pkg::ROOT_BITS;
   localparam int SW   = qnl_pkg::RAD_BITS;
   localparam int PSW  = 2 + L * CW;
   localparam int SQSW = PSW + L + L * SHW;
   localparam int DIVST = CW + 1;
   localparam int NV   = 10 + RW + DIVST;
   localparam logic [BW:0] BLEND_ONE = (BW + 1)'(1) << BW;
   localparam logic [CW-1:0] ONE_C  = CW'(1) << (CW - 2);
   localparam logic [CW-1:0] MAXP   = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] MINN   = {1'b1, {(CW-1){1'b0}}};

   logic en;
   logic [NV-1:0] vld_ff;

   logic signed [CW-1:0] a0_ff [0:L-1];
   logic signed [CW-1:0] b0_ff [0:L-1];
   logic [BW:0]          f0_ff;
   logic [BW:0]          f_in;
   logic                 byp_in;
   logic [L*CW-1:0]      pass_in;
   logic                 byp_ff  [0:8];
   logic [L*CW-1:0]      pass_ff [0:8];
   logic                 neg_ff;
   logic [LENW-1:0]      len_ff, len_in;
   logic                 zl5_ff, zl6_ff, zl7_ff, zl8_ff;
   logic [SW-1:0]        sum_ff;
   logic [MW-1:0]        mag_or;
   logic signed [2*CW+1:0] dot;

   logic signed [2*CW-1:0] prod [0:L-1];
   logic [MW-1:0]          mag  [0:L-1];
   logic                   sgn  [0:L-1];
   logic [SHW-1:0]         shm  [0:L-1];
   logic [2*SHW-1:0]       sq   [0:L-1];

   logic [SQSW-1:0] sq_side_in, sq_side_out;
   logic [RW-1:0]   root;
   logic [PSW-1:0]  ctl_ff [0:DIVST-1];
   logic [CW-1:0]   qv   [0:L-1];
   logic            qsg  [0:L-1];

   logic [4*CW-1:0] data_ff, data_in;
   logic            zl_out_ff;

   assign en         = !vld_ff[NV-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[NV-1];
   assign rsp_tdata  = OUTW'(data_ff);
   assign rsp_tuser  = zl_out_ff;

   always_comb begin
      f_in = req_tdata[8*CW +: BW+1];
      if (f_in > BLEND_ONE) begin
         f_in = BLEND_ONE;
      end
      byp_in  = (f_in == '0) || (f_in == BLEND_ONE);
      pass_in = (f_in == '0) ? req_tdata[0 +: L*CW] : req_tdata[L*CW +: L*CW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NV-2:0], req_tvalid};
      end
   end

   always_comb begin
      dot    = '0;
      mag_or = '0;
      for (int k = 0; k < L; k++) begin
         dot    = dot + (2*CW+2)'(prod[k]);
         mag_or = mag_or | mag[k];
      end
      len_in = '0;
      for (int j = 0; j < MW; j++) begin
         if (mag_or[j]) begin
            len_in = LENW'(j + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < L; k++) begin
            a0_ff[k] <= req_tdata[k*CW +: CW];
            b0_ff[k] <= req_tdata[(L+k)*CW +: CW];
         end
         f0_ff      <= f_in;
         byp_ff[0]  <= byp_in;
         pass_ff[0] <= pass_in;
         for (int s = 1; s < 9; s++) begin
            byp_ff[s]  <= byp_ff[s-1];
            pass_ff[s] <= pass_ff[s-1];
         end
         neg_ff <= dot[2*CW+1];
         len_ff <= len_in;
         zl5_ff <= (mag_or == '0);
         zl6_ff <= zl5_ff;
         zl7_ff <= zl6_ff;
         zl8_ff <= zl7_ff;
         sum_ff <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]) + SW'(sq[3]);
      end
   end

   for (genvar k = 0; k < L; k++) begin : g_lane
      qnl_lane #(.CW(CW), .BW(BW)) u_lane (
         .clock    (clock),
         .en       (en),
         .a        (a0_ff[k]),
         .b        (b0_ff[k]),
         .f        (f0_ff),
         .neg      (neg_ff),
         .len      (len_ff),
         .prod     (prod[k]),
         .mag      (mag[k]),
         .sign_out (sgn[k]),
         .sh_out   (shm[k]),
         .sq       (sq[k])
      );
      assign sq_side_in[PSW + k] = sgn[k];
      assign sq_side_in[PSW + L + k*SHW +: SHW] = shm[k];
   end
   assign sq_side_in[PSW-1:0] = {byp_ff[8], zl8_ff, pass_ff[8]};

   qnl_sqrt #(.SIDE_W(SQSW)) u_sqrt (
      .clock    (clock),
      .en       (en),
      .rad      (sum_ff),
      .side_in  (sq_side_in),
      .root     (root),
      .side_out (sq_side_out)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff[0] <= sq_side_out[PSW-1:0];
         for (int s = 1; s < DIVST; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
      end
   end

   for (genvar k = 0; k < L; k++) begin : g_div
      qnl_div #(.CW(CW), .SIDE_W(1)) u_div (
         .clock    (clock),
         .en       (en),
         .m        (sq_side_out[PSW + L + k*SHW +: SHW]),
         .root     (root),
         .side_in  (sq_side_out[PSW + k]),
         .q        (qv[k]),
         .side_out (qsg[k])
      );
   end

   always_comb begin
      for (int k = 0; k < L; k++) begin
         if (ctl_ff[DIVST-1][PSW-1]) begin
            data_in[k*CW +: CW] = ctl_ff[DIVST-1][k*CW +: CW];
         end else if (ctl_ff[DIVST-1][PSW-2]) begin
            data_in[k*CW +: CW] = (k == 2) ? ONE_C : '0;
         end else if (qsg[k]) begin
            data_in[k*CW +: CW] = (qv[k] > MINN) ? MINN : (-qv[k]);
         end else begin
            data_in[k*CW +: CW] = qv[k][CW-1] ? MAXP : qv[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff   <= data_in;
         zl_out_ff <= !ctl_ff[DIVST-1][PSW-1] && ctl_ff[DIVST-1][PSW-2];
      end
   end
endmodule
`default_nettype wire
